// ===== rtl/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg - shared codes and types for the stable max priority queue
// Operation and status codes, and the control word that drives every cell.
// ----------------------------------------------------------------------------
package spmq_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam int unsigned FIELD_WIDTH = 16;
    localparam int unsigned COUNT_FIELD_WIDTH = 5;

    // per-cycle command broadcast to the cell row
    typedef struct packed {
        logic ins;   // insert the new entry at its sorted place
        logic rem;   // pop the head, everything moves one slot up
    } t_cell_ctl;

endpackage

// ===== rtl/spmq_cell.sv =====
// ----------------------------------------------------------------------------
// spmq_cell - one slot of the sorted queue
// Holds one element and priority; keeps, loads the new entry, or takes the
// entry of a neighbour according to the broadcast command.
// ----------------------------------------------------------------------------
module spmq_cell #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                  i_clk,
    input  spmq_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_occupied,
    input  logic [DATA_WIDTH-1:0] i_new_elem,
    input  logic [DATA_WIDTH-1:0] i_new_prio,
    input  logic                  i_left_ge,
    input  logic [DATA_WIDTH-1:0] i_left_elem,
    input  logic [DATA_WIDTH-1:0] i_left_prio,
    input  logic [DATA_WIDTH-1:0] i_right_elem,
    input  logic [DATA_WIDTH-1:0] i_right_prio,
    output logic                  o_ge,
    output logic [DATA_WIDTH-1:0] o_elem,
    output logic [DATA_WIDTH-1:0] o_prio
);

    logic [DATA_WIDTH-1:0] r_elem;
    logic [DATA_WIDTH-1:0] r_prio;
    logic [DATA_WIDTH-1:0] n_elem;
    logic [DATA_WIDTH-1:0] n_prio;

    // equal priority stays ahead of the newcomer: arrival order is kept
    assign o_ge = i_occupied && (r_prio >= i_new_prio);

    always_comb begin
        n_elem = r_elem;
        n_prio = r_prio;
        if (i_ctl.ins) begin
            if (!o_ge) begin
                if (i_left_ge) begin
                    n_elem = i_new_elem;
                    n_prio = i_new_prio;
                end else begin
                    n_elem = i_left_elem;
                    n_prio = i_left_prio;
                end
            end
        end else if (i_ctl.rem) begin
            n_elem = i_right_elem;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
        r_prio <= n_prio;
    end

    assign o_elem = r_elem;
    assign o_prio = r_prio;

endmodule

// ===== rtl/stable_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_max_priority_queue - bounded, stable, max-first priority queue
// A row of QUEUE_DEPTH cells kept sorted by descending priority, head first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one operation per transfer:
//   insert (element, priority), remove head, or peek head. Output channel
//   (o_valid / i_ready) returns exactly one result per operation: element
//   and priority of the head (peek) or removed entry (remove), a status and
//   the entry count after the operation.
//   The result is registered at the edge that takes the operation. Throughput
//   is one operation per cycle while the receiver takes each result; every
//   cell compares its priority with the new one in parallel and loads itself,
//   the new entry or a neighbour's entry in that same cycle.
//   Entries of equal priority leave in arrival order.
//   Reset empties the queue (count to zero) and drops any pending result;
//   cell contents are not cleared and are never read while unoccupied.
//   While the receiver stalls the result register holds and o_ready is low,
//   so no operation is taken until the result is transferred; an operation
//   is taken in the same cycle as the waiting result leaves.
// ----------------------------------------------------------------------------
module stable_max_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned DATA_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_element,
    input  logic [15:0] i_priority_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_element,
    output logic [15:0] o_out_priority,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_count
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_elem;
    logic [DATA_WIDTH-1:0] r_out_prio;
    logic [1:0]            r_out_status;
    logic [DATA_WIDTH-1:0] n_out_elem;
    logic [DATA_WIDTH-1:0] n_out_prio;
    logic [1:0]            n_out_status;

    logic                  accept;
    logic                  full;
    logic                  empty;
    spmq_pkg::t_cell_ctl   ctl;
    logic [DATA_WIDTH-1:0] new_elem;
    logic [DATA_WIDTH-1:0] new_prio;

    logic [QUEUE_DEPTH-1:0] cell_ge;
    logic [DATA_WIDTH-1:0]  cell_elem [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0]  cell_prio [QUEUE_DEPTH];

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign empty    = (r_count == '0);
    assign new_elem = DATA_WIDTH'(i_element);
    assign new_prio = DATA_WIDTH'(i_priority_req);

    assign ctl.ins = accept && (i_func == spmq_pkg::FUNC_INSERT) && !full;
    assign ctl.rem = accept && (i_func == spmq_pkg::FUNC_REMOVE) && !empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                  left_ge;
        logic [DATA_WIDTH-1:0] left_elem;
        logic [DATA_WIDTH-1:0] left_prio;
        logic [DATA_WIDTH-1:0] right_elem;
        logic [DATA_WIDTH-1:0] right_prio;

        if (g == 0) begin : g_head
            // nothing ahead of the head: the newcomer lands here if it wins
            assign left_ge   = 1'b1;
            assign left_elem = new_elem;
            assign left_prio = new_prio;
        end else begin : g_body
            assign left_ge   = cell_ge[g-1];
            assign left_elem = cell_elem[g-1];
            assign left_prio = cell_prio[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_elem = cell_elem[g];
            assign right_prio = cell_prio[g];
        end else begin : g_inner
            assign right_elem = cell_elem[g+1];
            assign right_prio = cell_prio[g+1];
        end

        spmq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (r_count > CW'(g)),
            .i_new_elem   (new_elem),
            .i_new_prio   (new_prio),
            .i_left_ge    (left_ge),
            .i_left_elem  (left_elem),
            .i_left_prio  (left_prio),
            .i_right_elem (right_elem),
            .i_right_prio (right_prio),
            .o_ge         (cell_ge[g]),
            .o_elem       (cell_elem[g]),
            .o_prio       (cell_prio[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_elem   = '0;
        n_out_prio   = '0;
        n_out_status = spmq_pkg::STATUS_OK;
        unique case (i_func) inside
            spmq_pkg::FUNC_INSERT: begin
                if (full) begin
                    n_out_status = spmq_pkg::STATUS_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            spmq_pkg::FUNC_REMOVE, spmq_pkg::FUNC_PEEK: begin
                if (empty) begin
                    n_out_status = spmq_pkg::STATUS_EMPTY;
                end else begin
                    n_out_elem = cell_elem[0];
                    n_out_prio = cell_prio[0];
                    if (i_func == spmq_pkg::FUNC_REMOVE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_elem   <= n_out_elem;
            r_out_prio   <= n_out_prio;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_element  = spmq_pkg::FIELD_WIDTH'(r_out_elem);
    assign o_out_priority = spmq_pkg::FIELD_WIDTH'(r_out_prio);
    assign o_status       = r_out_status;
    assign o_entry_count  = spmq_pkg::COUNT_FIELD_WIDTH'(r_count);

endmodule
